// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Check prop at every rising clock edge, skipped while rst is high.
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Check prop at every rising clock edge, reset included.
`define ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_ALL(label, clk, prop)
`endif
`endif

// ===== hw/rtl/rdt_pkg.sv =====
// Types, constants and helpers of the segment-header connection machine.
package rdt_pkg;

  localparam logic [9:0]  HDR_BYTES     = 10'd12;
  localparam int          MAX_PAYLOAD   = 512;
  localparam logic [15:0] SEQ_MOD_RESET = 16'd25600;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_WAIT    = 3'd1,
    ST_CONN    = 3'd2,
    ST_CLOSING = 3'd3,
    ST_CLOSED  = 3'd4
  } conn_state_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] ack;
    logic        syn;
    logic        ack_flag;
    logic        fin;
    logic [9:0]  length;
    logic [14:0] initial_seq;
  } seg_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] ack;
    logic        syn;
    logic        ack_flag;
    logic        fin;
    logic [9:0]  payload;
    logic        first_data;
    logic        last_result;
  } res_t;

  typedef struct packed {
    logic [1:0]  nres;
    res_t [1:0]  res;
    conn_state_t state_next;
    logic [15:0] seq_next;
    logic [15:0] ack_next;
  } proc_t;

  function automatic res_t make_res(input logic [15:0] seq, input logic [15:0] ack,
                                    input logic syn, input logic ack_flag,
                                    input logic fin, input logic [9:0] payload,
                                    input logic first_data, input logic last_result);
    res_t r;
    r.seq         = seq;
    r.ack         = ack;
    r.syn         = syn;
    r.ack_flag    = ack_flag;
    r.fin         = fin;
    r.payload     = payload;
    r.first_data  = first_data;
    r.last_result = last_result;
    return r;
  endfunction

endpackage

// ===== hw/rtl/rdt_seg_proc.sv =====
// Next-state and result logic for one received segment header.
module rdt_seg_proc (
  input  rdt_pkg::seg_t        seg,
  input  rdt_pkg::conn_state_t conn_state,
  input  logic [15:0]          current_seq,
  input  logic [15:0]          current_ack,
  input  logic [15:0]          seq_modulus,
  output rdt_pkg::proc_t       proc
);
  import rdt_pkg::*;

  logic        data_seg;
  logic [9:0]  d;
  logic        len_ok;
  logic [16:0] sum;
  logic [15:0] adv_ack;
  logic [15:0] sf_ack;
  logic        mismatch;
  logic        fin_drop;

  always_comb begin
    data_seg = !seg.syn && seg.ack_flag && !seg.fin;
    d        = seg.length - HDR_BYTES;
    len_ok   = (seg.length >= HDR_BYTES) && ({3'b000, d} <= 13'(MAX_PAYLOAD));

    // Ack advance wraps past the modulus with one extra step
    sum      = {1'b0, seg.seq} + {7'd0, d};
    adv_ack  = (sum <= {1'b0, seq_modulus}) ? sum[15:0]
                                            : 16'(sum - {1'b0, seq_modulus} - 17'd1);
    sf_ack   = (seg.seq < seq_modulus) ? 16'(seg.seq + 16'd1) : 16'd0;

    // Drop only when both numbers disagree; seq+1 taken without wrap
    mismatch = (current_ack != seg.seq) &&
               (({1'b0, current_seq} + 17'd1) != {1'b0, seg.ack});
    fin_drop = (current_ack != seg.seq) && (seg.ack != 16'd0);

    proc.nres       = 2'd0;
    proc.res        = '0;
    proc.state_next = conn_state;
    proc.seq_next   = current_seq;
    proc.ack_next   = current_ack;

    if (len_ok) begin
      unique case (conn_state)
        ST_WAIT: begin
          if (data_seg && d != 10'd0 && !mismatch) begin
            proc.ack_next   = adv_ack;
            proc.seq_next   = seg.ack;
            proc.state_next = ST_CONN;
            proc.nres       = 2'd1;
            proc.res[0]     = make_res(seg.ack, adv_ack, 1'b0, 1'b1, 1'b0, d, 1'b1, 1'b1);
          end
        end
        ST_CONN: begin
          if (data_seg) begin
            if (!mismatch) begin
              proc.ack_next = adv_ack;
              proc.seq_next = seg.ack;
              proc.nres     = 2'd1;
              proc.res[0]   = make_res(seg.ack, adv_ack, 1'b0, 1'b1, 1'b0, d, 1'b0, 1'b1);
            end
          end else if (!seg.syn && !seg.ack_flag && seg.fin && !fin_drop &&
                       d == 10'd0) begin
            proc.ack_next   = sf_ack;
            proc.state_next = ST_CLOSED;
            proc.nres       = 2'd2;
            proc.res[0]     = make_res(current_seq, sf_ack, 1'b0, 1'b1, 1'b0, 10'd0,
                                       1'b0, 1'b0);
            proc.res[1]     = make_res(current_seq, 16'd0, 1'b0, 1'b0, 1'b1, 10'd0,
                                       1'b0, 1'b1);
          end
        end
        ST_CLOSED: begin
          if (data_seg && !mismatch && seg.seq <= seq_modulus) begin
            proc.state_next = ST_IDLE;
          end
        end
        default: begin
          if (seg.syn && !seg.ack_flag && !seg.fin && d == 10'd0) begin
            proc.ack_next   = sf_ack;
            proc.seq_next   = {1'b0, seg.initial_seq};
            proc.state_next = ST_WAIT;
            proc.nres       = 2'd1;
            proc.res[0]     = make_res({1'b0, seg.initial_seq}, sf_ack, 1'b1, 1'b1,
                                       1'b0, 10'd0, 1'b0, 1'b1);
          end else begin
            proc.state_next = ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/rdt_res_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one.
module rdt_res_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_cnt,
  input  rdt_pkg::res_t [1:0] push_data,
  input  logic                pop,
  output logic                room2,
  output logic                head_valid,
  output rdt_pkg::res_t       head
);
  import rdt_pkg::*;

  res_t                 mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic [RES_PTR_W-1:0] wr_ptr_inc;
  logic                 pop_go;

  assign wr_ptr_inc = wr_ptr + RES_PTR_W'(1);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign room2      = (count <= RES_CNT_W'(RES_DEPTH - 2));
  assign pop_go     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push_data[0];
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_inc] <= push_data[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push_cnt);
      rd_ptr <= rd_ptr + RES_PTR_W'(pop_go);
      count  <= count + RES_CNT_W'(push_cnt) - RES_CNT_W'(pop_go);
    end
  end

endmodule

// ===== hw/rtl/rdt_server_connection_fsm.sv =====
// Top level: receive-side connection machine for segment headers.
// An item waits in the input register; its results then pass through the result queue.
// Throughput: one item per cycle while the queue has room for two results; results
// leave at one per cycle while out_ready is high, a FIN's two results one by one.
// A four-entry result queue decouples the output port from the item register.
// Reset: clears connection state to idle, seq/ack to zero, modulus to 25600, queues empty.
`include "assert_macros.svh"

module rdt_server_connection_fsm (
  input  logic        clk,
  input  logic        rst,
  // Configuration: sequence modulus
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // Segment header channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] seg_seq,
  input  logic [15:0] seg_ack,
  input  logic        seg_syn,
  input  logic        seg_ack_flag,
  input  logic        seg_fin,
  input  logic [9:0]  seg_length,
  input  logic [14:0] initial_seq,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_seq,
  output logic [15:0] out_ack,
  output logic        out_syn,
  output logic        out_ack_flag,
  output logic        out_fin,
  output logic [9:0]  payload_accepted,
  output logic        first_data,
  output logic        last_result
);
  import rdt_pkg::*;

  // Configuration register
  logic [15:0] seq_modulus;

  // Connection state
  conn_state_t conn_state;
  logic [15:0] current_seq;
  logic [15:0] current_ack;

  // Input register: one header waiting for processing
  logic        in_full;
  seg_t        in_seg;

  logic        room2;
  logic        proc_go;
  proc_t       proc;
  res_t        head;
  logic [1:0]  push_cnt;

  // Process the held header whenever the queue can take two results;
  // the register frees up in the same cycle, so a new transfer lands at once.
  assign proc_go  = in_full && room2;
  assign in_ready = !in_full || proc_go;
  assign push_cnt = proc_go ? proc.nres : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_modulus <= SEQ_MOD_RESET;
    end else if (cfg_we) begin
      seq_modulus <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (proc_go) begin
      in_full <= 1'b0;
    end
  end

  // Payload register: hold the header until processed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_seg.seq         <= seg_seq;
      in_seg.ack         <= seg_ack;
      in_seg.syn         <= seg_syn;
      in_seg.ack_flag    <= seg_ack_flag;
      in_seg.fin         <= seg_fin;
      in_seg.length      <= seg_length;
      in_seg.initial_seq <= initial_seq;
    end
  end

  // Advance connection state once per processed header; a dropped header
  // leaves everything as is (the logic hands back the current values).
  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state  <= ST_IDLE;
      current_seq <= 16'd0;
      current_ack <= 16'd0;
    end else if (proc_go) begin
      conn_state  <= proc.state_next;
      current_seq <= proc.seq_next;
      current_ack <= proc.ack_next;
    end
  end

  rdt_seg_proc u_proc (
    .seg         (in_seg),
    .conn_state  (conn_state),
    .current_seq (current_seq),
    .current_ack (current_ack),
    .seq_modulus (seq_modulus),
    .proc        (proc)
  );

  rdt_res_fifo u_res_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_cnt   (push_cnt),
    .push_data  (proc.res),
    .pop        (out_ready),
    .room2      (room2),
    .head_valid (out_valid),
    .head       (head)
  );

  assign out_seq          = head.seq;
  assign out_ack          = head.ack;
  assign out_syn          = head.syn;
  assign out_ack_flag     = head.ack_flag;
  assign out_fin          = head.fin;
  assign payload_accepted = head.payload;
  assign first_data       = head.first_data;
  assign last_result      = head.last_result;

  // The closing state is never entered, so it is never stored
  `ASSERT_RST(a_closing_not_held, clk, rst, conn_state != ST_CLOSING)
  // A two-result header is always a FIN that closes the connection
  `ASSERT_RST(a_fin_closes, clk, rst, (proc_go && proc.nres == 2'd2) |=> (conn_state == ST_CLOSED))
  // Payload only rides on plain ACK results
  `ASSERT_RST(a_pay_on_ack, clk, rst, (out_valid && payload_accepted != 10'd0) |-> (out_ack_flag && !out_fin && !out_syn))
  // Nothing is offered right after reset
  `ASSERT_ALL(a_rst_empty, clk, rst |=> !out_valid)

endmodule
